[rtl/assert_macros.svh]
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the start code splitter RTL
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rstn, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
        else $error(msg);

// antecedent in one cycle implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLIES(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

`endif

[rtl/nalsc_pkg.sv]
// ---------------------------------------------------------------------------
// nalsc_pkg
// Types and constants shared by the start code splitter modules
// ---------------------------------------------------------------------------
package nalsc_pkg;

    // held tail of the stream
    localparam int HOLD_DEPTH = 4;
    // results one byte can cause: all held bytes plus the byte itself
    localparam int MAX_PUSH   = HOLD_DEPTH + 1;
    // output queue depth
    localparam int OQ_DEPTH   = 8;

    // last byte of the start code 00 00 01
    localparam logic [7:0] SC_ONE  = 8'h01;
    localparam logic [7:0] SC_ZERO = 8'h00;

    typedef logic [7:0] byte_t;

    // group of results produced by one byte, written to the queue at once
    typedef struct packed {
        logic [2:0]                 cnt;        // number of results, 0..5
        logic                       mark_last;  // final result ends a unit
        logic [MAX_PUSH-1:0][7:0]   data;       // result bytes, oldest first
    } push_t;

endpackage

[rtl/nalsc_core.sv]
// ---------------------------------------------------------------------------
// nalsc_core
// Input register, holdback state and start code decision for one byte
// ---------------------------------------------------------------------------
module nalsc_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [7:0]          s_data_byte,
    input  logic                s_end_of_stream,
    input  logic                room,
    output nalsc_pkg::push_t    push
);
    import nalsc_pkg::*;

    // input register
    logic   in_valid_reg;
    byte_t  in_byte_reg;
    logic   in_eos_reg;

    // holdback state
    logic                   seeking_reg, seeking_next;
    byte_t [HOLD_DEPTH-1:0] held_reg, held_next;
    logic [2:0]             held_count_reg, held_count_next;

    logic                   fire;
    byte_t [MAX_PUSH-1:0]   buf_w;
    logic [2:0]             n, t, z, k, base, m;
    logic                   code_done;
    logic                   run;
    logic [2:0]             pos;
    logic [3:0]             idx;

    assign fire    = in_valid_reg && room;
    assign s_ready = !in_valid_reg || room;

    // input register load
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (s_valid && s_ready) begin
            in_byte_reg <= s_data_byte;
            in_eos_reg  <= s_end_of_stream;
        end
    end

    // held tail followed by the new byte
    always_comb begin
        n = (held_count_reg > 3'(HOLD_DEPTH)) ? 3'(HOLD_DEPTH) : held_count_reg;
        t = n + 3'd1;
        for (int i = 0; i < MAX_PUSH; i++) begin
            if (i < HOLD_DEPTH && 3'(i) < n) begin
                buf_w[i] = held_reg[i % HOLD_DEPTH];
            end else if (3'(i) == n) begin
                buf_w[i] = in_byte_reg;
            end else begin
                buf_w[i] = SC_ZERO;
            end
        end
        code_done = (in_byte_reg == SC_ONE) && (n >= 3'd2)
                    && (held_reg[2'(n - 3'd2)] == SC_ZERO)
                    && (held_reg[2'(n - 3'd1)] == SC_ZERO);
    end

    // trailing zero run and holdback length
    always_comb begin
        z   = 3'd0;
        run = 1'b1;
        pos = 3'd0;
        for (int j = 0; j < MAX_PUSH; j++) begin
            pos = t - 3'd1 - 3'(j);
            if (run && (3'(j) < t)) begin
                if (buf_w[pos] == SC_ZERO) begin
                    z = z + 3'd1;
                end else begin
                    run = 1'b0;
                end
            end
        end
        if (seeking_reg) begin
            k = (t < 3'd2) ? t : 3'd2;
        end else begin
            k = z + 3'd1;
            if (k > 3'(HOLD_DEPTH)) k = 3'(HOLD_DEPTH);
            if (k > t) k = t;
        end
        base = t - k;
        // payload left when a start code completes, minus a trailing zero
        m = n - 3'd2;
        if (m > 3'd0 && held_reg[2'(m - 3'd1)] == SC_ZERO) m = m - 3'd1;
    end

    // next state and results
    always_comb begin
        seeking_next    = seeking_reg;
        held_next       = held_reg;
        held_count_next = held_count_reg;
        push.cnt        = 3'd0;
        push.mark_last  = 1'b0;
        push.data       = buf_w;
        idx             = 4'd0;
        if (fire) begin
            priority if (code_done) begin
                if (!seeking_reg) begin
                    push.cnt       = m;
                    push.mark_last = 1'b1;
                end
                seeking_next    = 1'b0;
                held_count_next = 3'd0;
            end else if (in_eos_reg && !seeking_reg) begin
                push.cnt       = t;
                push.mark_last = 1'b1;
            end else begin
                push.cnt        = seeking_reg ? 3'd0 : base;
                held_count_next = k;
                for (int j = 0; j < HOLD_DEPTH; j++) begin
                    idx = {1'b0, base} + 4'(j);
                    if (3'(j) < k && idx < 4'(MAX_PUSH)) begin
                        held_next[j] = buf_w[idx[2:0]];
                    end
                end
            end
            // end of stream returns to the reset state
            if (in_eos_reg) begin
                seeking_next    = 1'b1;
                held_count_next = 3'd0;
            end
        end
    end

    // holdback state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seeking_reg    <= 1'b1;
            held_count_reg <= 3'd0;
        end else begin
            seeking_reg    <= seeking_next;
            held_count_reg <= held_count_next;
        end
        held_reg <= held_next;
    end

`include "assert_macros.svh"

    `ASSERT_ALWAYS(a_held_range, aclk, aresetn, held_count_reg <= 3'(HOLD_DEPTH), "held count above depth")
    `ASSERT_IMPLIES(a_seek_short, aclk, aresetn, seeking_reg, held_count_reg <= 3'd2, "seek holds more than two bytes")
    `ASSERT_NEXT(a_eos_reset, aclk, aresetn, fire && in_eos_reg, seeking_reg && held_count_reg == 3'd0, "end of stream did not reset state")

endmodule

[rtl/nalsc_outq.sv]
// ---------------------------------------------------------------------------
// nalsc_outq
// Result queue taking up to five bytes at once and draining one per cycle while m_ready is high
// ---------------------------------------------------------------------------
module nalsc_outq (
    input  logic                aclk,
    input  logic                aresetn,
    input  nalsc_pkg::push_t    push,
    output logic                room,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [7:0]          m_nal_byte,
    output logic                m_last_of_nal
);
    import nalsc_pkg::*;

    byte_t [OQ_DEPTH-1:0]   data_reg, data_next;
    logic  [OQ_DEPTH-1:0]   last_reg, last_next;
    logic  [3:0]            count_reg, count_next;
    logic  [3:0]            base;
    logic  [3:0]            off;
    logic                   pop;

    assign m_valid       = (count_reg != 4'd0);
    assign m_nal_byte    = data_reg[0];
    assign m_last_of_nal = last_reg[0];
    assign pop           = m_valid && m_ready;
    assign room          = (count_reg <= 4'(OQ_DEPTH - MAX_PUSH));

    // shift on pop, then append the pushed group behind the survivors
    always_comb begin
        base = count_reg - {3'b000, pop};
        off  = 4'd0;
        for (int i = 0; i < OQ_DEPTH; i++) begin
            if (pop && i < OQ_DEPTH - 1) begin
                data_next[i] = data_reg[(i + 1) % OQ_DEPTH];
                last_next[i] = last_reg[(i + 1) % OQ_DEPTH];
            end else begin
                data_next[i] = data_reg[i];
                last_next[i] = last_reg[i];
            end
            off = 4'(i) - base;
            if (4'(i) >= base && off < {1'b0, push.cnt}) begin
                data_next[i] = push.data[off[2:0]];
                last_next[i] = push.mark_last && (off == {1'b0, push.cnt} - 4'd1);
            end
        end
        count_next = base + {1'b0, push.cnt};
    end

    // queue registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 4'd0;
        end else begin
            count_reg <= count_next;
        end
        data_reg <= data_next;
        last_reg <= last_next;
    end

`include "assert_macros.svh"

    `ASSERT_ALWAYS(a_count_range, aclk, aresetn, count_reg <= 4'(OQ_DEPTH), "queue count above depth")
    `ASSERT_IMPLIES(a_push_room, aclk, aresetn, push.cnt != 3'd0, room, "push without room")
    `ASSERT_NEXT(a_pop_only, aclk, aresetn, pop && push.cnt == 3'd0, count_reg == $past(count_reg) - 4'd1, "pop did not drop one entry")

endmodule

[rtl/annexb_nal_start_code_splitter.sv]
// ---------------------------------------------------------------------------
// annexb_nal_start_code_splitter
// Splits an Annex B byte stream into NAL units at 00 00 01 start codes
// ---------------------------------------------------------------------------
// Usage:
//  The s_ channel takes one stream byte per transaction, with s_end_of_stream
//  set on the final byte of a stream. The m_ channel gives NAL unit payload
//  bytes one per transaction, m_last_of_nal set on the final byte of a unit.
//  Bytes before the first start code are dropped, start code zeros are
//  removed, and up to four bytes are held until their role is known.
// Timing:
//  A byte is registered at acceptance and decided while it waits in the input
//  register with room in the queue; its results are written into the output
//  queue, whose head entry is presented on m_. Sustained throughput is one
//  byte per cycle while m_ready is high. A byte can release up to five
//  results at once; they go into an eight-entry output queue drained one per
//  cycle while m_ready is high, and s_ready drops while the queue holds more
//  than three entries and a decided byte waits in the input register.
// Reset and stall:
//  aresetn (synchronous, active low) empties the queue and the input register
//  and returns to searching for the first start code. When the receiver
//  stalls, m_ holds its byte, the queue fills and then s_ready drops.
// ---------------------------------------------------------------------------
module annexb_nal_start_code_splitter (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_end_of_stream,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_nal_byte,
    output logic        m_last_of_nal
);
    import nalsc_pkg::*;

    push_t  push;
    logic   room;

    // holdback and start code decision
    nalsc_core u_core (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data_byte     (s_data_byte),
        .s_end_of_stream (s_end_of_stream),
        .room            (room),
        .push            (push)
    );

    // result queue
    nalsc_outq u_outq (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .push          (push),
        .room          (room),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_nal_byte    (m_nal_byte),
        .m_last_of_nal (m_last_of_nal)
    );

endmodule
